// File: sv/hbm_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor package
// Shared types and constants of the heartbeat timeout monitor.
// ----------------------------------------------------------------------------
package hbm_pkg;

	localparam int MAX_UNITS  = 8;
	localparam int ID_W       = 8;
	localparam int TIME_W     = 32;
	localparam int TIMEOUT_W  = 16;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic MODE_RECEIVE = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_UNITS = 3'd0,
		CFG_UNIT_IDS     = 3'd1,
		CFG_TIMEOUTS_LO  = 3'd2,
		CFG_TIMEOUTS_HI  = 3'd3,
		CFG_REPORT_MODE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   unit_id;
		logic [TIME_W-1:0] now_ms;
	} req_item_t;

	typedef struct packed {
		logic [MAX_UNITS-1:0] connected_mask;
		logic [MAX_UNITS-1:0] report_mask;
		logic                 id_matched;
	} rsp_item_t;

endpackage

// File: sv/hbm_req_if.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor request channel
// Valid/ready channel carrying receive events and time ticks.
// ----------------------------------------------------------------------------
interface hbm_req_if import hbm_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/hbm_rsp_if.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor response channel
// Valid/ready channel carrying the connected and report masks.
// ----------------------------------------------------------------------------
interface hbm_rsp_if import hbm_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/unit_heartbeat_timeout_monitor_top.sv
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor
// Tracks link state of up to NUM_UNITS remote units by heartbeat.
//
// Channels: req takes one transaction per receive event (mode 0, unit_id,
// now_ms) or time tick (mode 1, now_ms); rsp returns one transaction per
// request with the connected mask, the report mask and id_matched.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); a
// write of the unit count also clears all link and last-heard state.
// Operation: one compare/subtract unit walks the active entries (at most
// NUM_UNITS), one entry a cycle, then the result is registered into rsp.
// A request is accepted only while idle, so a new request is taken only
// after the previous one has finished.
// The rsp output register holds a finished result while the receiver
// stalls; the next request is still accepted and processed, and waits in
// its final step until the output register frees.
// Reset clears all configuration, link flags and last-heard times.
// ----------------------------------------------------------------------------
module unit_heartbeat_timeout_monitor_top import hbm_pkg::*; #(
	parameter int NUM_UNITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hbm_req_if.sink               req,
	hbm_rsp_if.source             rsp
);

	localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]          active_units_q;
	logic [MAX_UNITS*ID_W-1:0]   unit_ids_q;
	logic [2*CFG_DATA_W-1:0]     timeouts_q;
	logic                        report_mode_q;

	logic [NUM_UNITS-1:0]        link_up_q;
	logic [TIME_W-1:0]           last_heard_q [NUM_UNITS];

	req_item_t                   item_q;
	logic [IDX_W-1:0]            idx_q;
	logic [NUM_UNITS-1:0]        conn_q;
	logic [NUM_UNITS-1:0]        rep_q;
	logic                        matched_q;

	rsp_item_t                   rsp_q;
	logic                        rsp_valid_q;

	logic [COUNT_W-1:0]          units_in_use;
	logic                        accept;
	logic                        step_en;
	logic                        load_out;
	logic                        last_step;

	logic [ID_W-1:0]             entry_id;
	logic [TIMEOUT_W-1:0]        entry_timeout;
	logic [TIME_W-1:0]           entry_last;
	logic [TIME_W-1:0]           elapsed;
	logic                        hit;
	logic                        expire;
	logic                        new_link;
	logic [TIME_W-1:0]           new_last;

	assign units_in_use = (active_units_q > COUNT_W'(NUM_UNITS)) ?
		COUNT_W'(NUM_UNITS) : active_units_q;

	assign accept    = req.valid && req.ready;
	assign last_step = (COUNT_W'(idx_q) + COUNT_W'(1)) == units_in_use;

	// shared per-entry unit
	assign entry_id      = unit_ids_q[ID_W*idx_q +: ID_W];
	assign entry_timeout = timeouts_q[TIMEOUT_W*idx_q +: TIMEOUT_W];
	assign entry_last    = last_heard_q[idx_q];
	assign elapsed       = item_q.now_ms - entry_last;

	assign hit      = (item_q.mode == MODE_RECEIVE) && !matched_q &&
		(entry_id == item_q.unit_id);
	assign expire   = (item_q.mode == MODE_TICK) && link_up_q[idx_q] &&
		(elapsed > TIME_W'(entry_timeout));
	assign new_link = hit ? 1'b1 : (expire ? 1'b0 : link_up_q[idx_q]);
	assign new_last = hit ? item_q.now_ms : entry_last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (units_in_use == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		step_en   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: step_en   = 1'b1;
			ST_DONE: load_out  = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_units_q <= '0;
			unit_ids_q     <= '0;
			timeouts_q     <= '0;
			report_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_UNITS: active_units_q <= cfg_data[COUNT_W-1:0];
				CFG_UNIT_IDS:     unit_ids_q <= cfg_data;
				CFG_TIMEOUTS_LO:  timeouts_q[CFG_DATA_W-1:0] <= cfg_data;
				CFG_TIMEOUTS_HI:  timeouts_q[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
				CFG_REPORT_MODE:  report_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q <= '0;
			for (int i = 0; i < NUM_UNITS; i++) begin
				last_heard_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index == CFG_ACTIVE_UNITS)) begin
			link_up_q <= '0;
			for (int i = 0; i < NUM_UNITS; i++) begin
				last_heard_q[i] <= '0;
			end
		end else if (step_en) begin
			link_up_q[idx_q]    <= new_link;
			last_heard_q[idx_q] <= new_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			conn_q    <= '0;
			rep_q     <= '0;
			matched_q <= 1'b0;
		end else if (accept) begin
			idx_q     <= '0;
			conn_q    <= '0;
			rep_q     <= '0;
			matched_q <= 1'b0;
		end else if (step_en) begin
			idx_q         <= idx_q + IDX_W'(1);
			conn_q[idx_q] <= new_link;
			rep_q[idx_q]  <= !new_link && (!report_mode_q || (new_last != '0));
			matched_q     <= matched_q || hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q.connected_mask <= MAX_UNITS'(conn_q);
			rsp_q.report_mask    <= MAX_UNITS'(rep_q);
			rsp_q.id_matched     <= matched_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// File: sv/hbm_checker.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module hbm_checker import hbm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("rsp payload changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous still in work");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response appeared one cycle after request");

	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_data.connected_mask & rsp_data.report_mask) == '0))
		else $error("entry both connected and reported");

endmodule

bind unit_heartbeat_timeout_monitor_top hbm_checker u_hbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
